// ===== rtl/eelr_pkg.sv =====
// eelr_pkg: shared types, constants and helpers of the explicit embedding level resolver
// no dependencies; used by the channel interfaces, the stack ram user and the top level

package eelr_pkg;

  localparam int MaxLevel       = 125;
  localparam int StackDepth     = 127;
  localparam int StackAw        = $clog2(StackDepth);
  localparam int LevelW         = 7;
  localparam int ClassW         = 5;
  localparam int CounterBitsDef = 16;
  localparam int ValidIsoMax    = 127;

  typedef enum logic [ClassW-1:0] {
    ClsL   = 5'd0,
    ClsR   = 5'd1,
    ClsAl  = 5'd2,
    ClsEn  = 5'd3,
    ClsEs  = 5'd4,
    ClsEt  = 5'd5,
    ClsAn  = 5'd6,
    ClsCs  = 5'd7,
    ClsNsm = 5'd8,
    ClsBn  = 5'd9,
    ClsB   = 5'd10,
    ClsS   = 5'd11,
    ClsWs  = 5'd12,
    ClsOn  = 5'd13,
    ClsLre = 5'd14,
    ClsLro = 5'd15,
    ClsRle = 5'd16,
    ClsRlo = 5'd17,
    ClsPdf = 5'd18,
    ClsLri = 5'd19,
    ClsRli = 5'd20,
    ClsFsi = 5'd21,
    ClsPdi = 5'd22
  } bidi_class_e;

  typedef enum logic [1:0] {
    OvrNone = 2'd0,
    OvrL    = 2'd1,
    OvrR    = 2'd2
  } ovr_e;

  typedef struct packed {
    logic              iso;
    ovr_e              ovr;
    logic [LevelW-1:0] level;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StSeek,
    StLoad
  } state_e;

  function automatic logic [ClassW-1:0] apply_ovr(logic [ClassW-1:0] cls, ovr_e ovr);
    logic [ClassW-1:0] res;
    case (ovr)
      OvrL:    res = ClsL;
      OvrR:    res = ClsR;
      default: res = cls;
    endcase
    return res;
  endfunction

  function automatic logic [LevelW:0] next_odd(logic [LevelW-1:0] x);
    return x[0] ? ({1'b0, x} + (LevelW+1)'(2)) : ({1'b0, x} + (LevelW+1)'(1));
  endfunction

  function automatic logic [LevelW:0] next_even(logic [LevelW-1:0] x);
    return x[0] ? ({1'b0, x} + (LevelW+1)'(1)) : ({1'b0, x} + (LevelW+1)'(2));
  endfunction

endpackage

// ===== rtl/eelr_in_if.sv =====
// eelr_in_if: input channel, one character class per beat
// depends on eelr_pkg

interface eelr_in_if;
  logic                        valid;
  logic                        ready;
  logic [eelr_pkg::ClassW-1:0] bidi_class;
  logic                        paragraph_start;
  logic                        paragraph_level;

  modport source (output valid, bidi_class, paragraph_start, paragraph_level, input ready);
  modport sink   (input valid, bidi_class, paragraph_start, paragraph_level, output ready);
endinterface

// ===== rtl/eelr_out_if.sv =====
// eelr_out_if: result channel, one resolved character per beat
// depends on eelr_pkg

interface eelr_out_if;
  logic                        valid;
  logic                        ready;
  logic [eelr_pkg::LevelW-1:0] embedding_level;
  logic [eelr_pkg::ClassW-1:0] resolved_class;
  logic                        removed_by_x9;

  modport source (output valid, embedding_level, resolved_class, removed_by_x9, input ready);
  modport sink   (input valid, embedding_level, resolved_class, removed_by_x9, output ready);
endinterface

// ===== rtl/eelr_ram.sv =====
// eelr_ram: generic single write port ram with registered read
// no dependencies

module eelr_ram #(
  parameter int Width = 10,
  parameter int Depth = 127,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/explicit_embedding_level_resolver_unit.sv =====
// explicit_embedding_level_resolver_unit: explicit embedding levels for one character per beat
// most classes: accepted in idle, resolved in the execute state; next input once back in idle and the result is taken
// a pdf that pops the stack: result from the execute state, then a load state reloads the top from ram
// a pdi that closes an isolate: a seek state and a load state per stack entry popped (ram read per pop)
// reset: stack pointer, counters, output valid and sequencer cleared; stack ram undefined
// until the first paragraph start; depends on eelr_pkg, eelr_in_if, eelr_out_if, eelr_ram

module explicit_embedding_level_resolver_unit #(
  parameter int CounterBits = eelr_pkg::CounterBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eelr_in_if.sink    in_i,
  eelr_out_if.source out_o
);

  localparam logic [CounterBits-1:0] CntMax = {CounterBits{1'b1}};

  eelr_pkg::state_e state_q, state_d;

  logic [eelr_pkg::ClassW-1:0]  cls_q, cls_d;
  eelr_pkg::entry_t             top_q, top_d;
  logic [eelr_pkg::StackAw-1:0] sp_q, sp_d;
  logic [eelr_pkg::LevelW-1:0]  bottom_q, bottom_d;
  logic [CounterBits-1:0]       ovf_iso_q, ovf_iso_d;
  logic [CounterBits-1:0]       ovf_emb_q, ovf_emb_d;
  logic [eelr_pkg::LevelW-1:0]  viso_q, viso_d;
  logic                         final_q, final_d;

  logic                        out_valid_q, out_valid_d;
  logic [eelr_pkg::LevelW-1:0] out_level_q, out_level_d;
  logic [eelr_pkg::ClassW-1:0] out_class_q, out_class_d;
  logic                        out_removed_q, out_removed_d;

  logic                         ram_we;
  logic [eelr_pkg::StackAw-1:0] ram_waddr;
  eelr_pkg::entry_t             ram_wdata;
  logic [eelr_pkg::StackAw-1:0] ram_raddr;
  logic [eelr_pkg::EntryW-1:0]  ram_rdata;
  eelr_pkg::entry_t             rd_entry;

  logic                         in_fire, out_fire;
  logic [eelr_pkg::StackAw-1:0] sp_inc, sp_dec;
  logic                         is_odd;
  logic [eelr_pkg::LevelW:0]    new_level;
  logic                         push_ok;
  logic                         pdf_pop;
  logic                         pdi_seek;
  eelr_pkg::entry_t             push_entry;
  eelr_pkg::ovr_e               push_ovr;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign rd_entry = eelr_pkg::entry_t'(ram_rdata);

  assign sp_inc = sp_q + eelr_pkg::StackAw'(1);
  assign sp_dec = sp_q - eelr_pkg::StackAw'(1);

  assign is_odd    = (cls_q == eelr_pkg::ClsRle) || (cls_q == eelr_pkg::ClsRlo) ||
                     (cls_q == eelr_pkg::ClsRli);
  assign new_level = is_odd ? eelr_pkg::next_odd(top_q.level)
                            : eelr_pkg::next_even(top_q.level);
  assign push_ok   = (new_level <= (eelr_pkg::LevelW+1)'(eelr_pkg::MaxLevel)) &&
                     (ovf_iso_q == '0) && (ovf_emb_q == '0) &&
                     (sp_q < eelr_pkg::StackAw'(eelr_pkg::StackDepth - 1));

  always_comb begin
    case (cls_q)
      eelr_pkg::ClsRlo: push_ovr = eelr_pkg::OvrR;
      eelr_pkg::ClsLro: push_ovr = eelr_pkg::OvrL;
      default:          push_ovr = eelr_pkg::OvrNone;
    endcase
  end

  assign push_entry.iso   = (cls_q == eelr_pkg::ClsLri) || (cls_q == eelr_pkg::ClsRli);
  assign push_entry.ovr   = push_ovr;
  assign push_entry.level = new_level[eelr_pkg::LevelW-1:0];

  assign pdf_pop  = (ovf_iso_q == '0) && (ovf_emb_q == '0) && !top_q.iso && (sp_q != '0);
  assign pdi_seek = (ovf_iso_q == '0) && (viso_q != '0);

  assign in_i.ready            = (state_q == eelr_pkg::StIdle) && (!out_valid_q || out_o.ready);
  assign out_o.valid           = out_valid_q;
  assign out_o.embedding_level = out_level_q;
  assign out_o.resolved_class  = out_class_q;
  assign out_o.removed_by_x9   = out_removed_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eelr_pkg::StIdle: begin
        if (in_fire) begin
          state_d = eelr_pkg::StExec;
        end
      end
      eelr_pkg::StExec: begin
        if (cls_q == eelr_pkg::ClsPdi && pdi_seek) begin
          state_d = eelr_pkg::StSeek;
        end else if (cls_q == eelr_pkg::ClsPdf && pdf_pop) begin
          state_d = eelr_pkg::StLoad;
        end else begin
          state_d = eelr_pkg::StIdle;
        end
      end
      eelr_pkg::StSeek: begin
        state_d = (sp_q != '0) ? eelr_pkg::StLoad : eelr_pkg::StIdle;
      end
      eelr_pkg::StLoad: begin
        if (cls_q == eelr_pkg::ClsPdf || final_q) begin
          state_d = eelr_pkg::StIdle;
        end else begin
          state_d = eelr_pkg::StSeek;
        end
      end
      default: state_d = eelr_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cls_d         = cls_q;
    top_d         = top_q;
    sp_d          = sp_q;
    bottom_d      = bottom_q;
    ovf_iso_d     = ovf_iso_q;
    ovf_emb_d     = ovf_emb_q;
    viso_d        = viso_q;
    final_d       = final_q;
    out_valid_d   = out_valid_q && !out_fire;
    out_level_d   = out_level_q;
    out_class_d   = out_class_q;
    out_removed_d = out_removed_q;
    ram_we        = 1'b0;
    ram_waddr     = sp_inc;
    ram_wdata     = push_entry;
    ram_raddr     = sp_dec;

    unique case (state_q)
      eelr_pkg::StIdle: begin
        if (in_fire) begin
          cls_d = in_i.bidi_class;
          if (in_i.paragraph_start) begin
            sp_d            = '0;
            ovf_iso_d       = '0;
            ovf_emb_d       = '0;
            viso_d          = '0;
            bottom_d        = eelr_pkg::LevelW'(in_i.paragraph_level);
            top_d.iso       = 1'b0;
            top_d.ovr       = eelr_pkg::OvrNone;
            top_d.level     = eelr_pkg::LevelW'(in_i.paragraph_level);
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata.iso   = 1'b0;
            ram_wdata.ovr   = eelr_pkg::OvrNone;
            ram_wdata.level = eelr_pkg::LevelW'(in_i.paragraph_level);
          end
        end
      end
      eelr_pkg::StExec: begin
        out_valid_d   = 1'b1;
        out_level_d   = top_q.level;
        out_class_d   = cls_q;
        out_removed_d = 1'b0;
        case (cls_q) inside
          eelr_pkg::ClsLre, eelr_pkg::ClsLro, eelr_pkg::ClsRle, eelr_pkg::ClsRlo: begin
            out_removed_d = 1'b1;
            if (push_ok) begin
              sp_d   = sp_inc;
              top_d  = push_entry;
              ram_we = 1'b1;
            end else if (ovf_iso_q == '0 && ovf_emb_q != CntMax) begin
              ovf_emb_d = ovf_emb_q + CounterBits'(1);
            end
          end
          eelr_pkg::ClsLri, eelr_pkg::ClsRli: begin
            out_class_d = eelr_pkg::apply_ovr(cls_q, top_q.ovr);
            if (push_ok) begin
              sp_d   = sp_inc;
              top_d  = push_entry;
              ram_we = 1'b1;
              if (viso_q < eelr_pkg::LevelW'(eelr_pkg::ValidIsoMax)) begin
                viso_d = viso_q + eelr_pkg::LevelW'(1);
              end
            end else if (ovf_iso_q != CntMax) begin
              ovf_iso_d = ovf_iso_q + CounterBits'(1);
            end
          end
          eelr_pkg::ClsPdi: begin
            out_class_d = eelr_pkg::apply_ovr(cls_q, top_q.ovr);
            if (ovf_iso_q != '0) begin
              ovf_iso_d = ovf_iso_q - CounterBits'(1);
            end else if (viso_q != '0) begin
              ovf_emb_d   = '0;
              viso_d      = viso_q - eelr_pkg::LevelW'(1);
              out_valid_d = 1'b0;
            end
          end
          eelr_pkg::ClsPdf: begin
            out_removed_d = 1'b1;
            if (ovf_iso_q != '0) begin
              ovf_iso_d = ovf_iso_q;
            end else if (ovf_emb_q != '0) begin
              ovf_emb_d = ovf_emb_q - CounterBits'(1);
            end else if (pdf_pop) begin
              sp_d = sp_dec;
            end
          end
          eelr_pkg::ClsBn: begin
            out_removed_d = 1'b1;
          end
          eelr_pkg::ClsB: begin
            out_level_d = bottom_q;
            sp_d        = '0;
            ovf_iso_d   = '0;
            ovf_emb_d   = '0;
            viso_d      = '0;
            top_d.iso   = 1'b0;
            top_d.ovr   = eelr_pkg::OvrNone;
            top_d.level = bottom_q;
          end
          default: begin
            out_class_d = eelr_pkg::apply_ovr(cls_q, top_q.ovr);
          end
        endcase
      end
      eelr_pkg::StSeek: begin
        if (sp_q != '0) begin
          sp_d    = sp_dec;
          final_d = top_q.iso;
        end else begin
          out_valid_d   = 1'b1;
          out_level_d   = top_q.level;
          out_class_d   = eelr_pkg::apply_ovr(cls_q, top_q.ovr);
          out_removed_d = 1'b0;
        end
      end
      eelr_pkg::StLoad: begin
        top_d = rd_entry;
        if (cls_q != eelr_pkg::ClsPdf && final_q) begin
          out_valid_d   = 1'b1;
          out_level_d   = rd_entry.level;
          out_class_d   = eelr_pkg::apply_ovr(cls_q, rd_entry.ovr);
          out_removed_d = 1'b0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_fire;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eelr_pkg::StIdle;
      sp_q        <= '0;
      ovf_iso_q   <= '0;
      ovf_emb_q   <= '0;
      viso_q      <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      ovf_iso_q   <= ovf_iso_d;
      ovf_emb_q   <= ovf_emb_d;
      viso_q      <= viso_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q         <= cls_d;
    top_q         <= top_d;
    bottom_q      <= bottom_d;
    out_level_q   <= out_level_d;
    out_class_q   <= out_class_d;
    out_removed_q <= out_removed_d;
  end

  eelr_ram #(
    .Width (eelr_pkg::EntryW),
    .Depth (eelr_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // stack pointer stays inside the memory
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= eelr_pkg::StackAw'(eelr_pkg::StackDepth - 1))
    else $error("stack pointer beyond stack depth");

  // every valid isolate owns a stack entry
  a_viso_le_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    viso_q <= eelr_pkg::LevelW'(sp_q))
    else $error("valid isolate count exceeds stack entries");

  // stack writes happen only at accept or in the execute step
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == eelr_pkg::StIdle || state_q == eelr_pkg::StExec))
    else $error("stack write during pop sequence");

  // only a pdi walks the stack
  a_seek_pdi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eelr_pkg::StSeek) |-> (cls_q == eelr_pkg::ClsPdi))
    else $error("stack walk for a class other than pdi");

  // a result beat is produced once per item: no new beat while one waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result dropped");

endmodule

// ===== tb/explicit_embedding_level_resolver_unit_test.sv =====
// explicit_embedding_level_resolver_unit_test: self-checking bench for the explicit level resolver
// predicts level, class and x9 flag per character and checks each result beat in order
// depends on eelr_pkg, eelr_in_if, eelr_out_if and the explicit_embedding_level_resolver_unit rtl
`timescale 1ns / 1ps

module explicit_embedding_level_resolver_unit_test;

  localparam int CounterBits = 16;
  localparam int unsigned CounterMax = (32'd1 << CounterBits) - 1;

  typedef struct packed {
    logic [eelr_pkg::LevelW-1:0] level;
    logic [eelr_pkg::ClassW-1:0] cls;
    logic                        removed;
  } char_res_t;

  logic clk_i;
  logic rst_ni;

  eelr_in_if  in_if ();
  eelr_out_if out_if ();

  explicit_embedding_level_resolver_unit #(
    .CounterBits(CounterBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  eelr_pkg::entry_t lvl_stack[eelr_pkg::StackDepth];
  int unsigned      stk_top;
  int unsigned      ovf_iso;
  int unsigned      ovf_emb;
  int unsigned      iso_open;

  char_res_t   pending_res[$];
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void clear_levels();
    stk_top  = 0;
    ovf_iso  = 0;
    ovf_emb  = 0;
    iso_open = 0;
  endfunction

  function automatic logic [eelr_pkg::ClassW-1:0] with_override(
      logic [eelr_pkg::ClassW-1:0] cls, eelr_pkg::ovr_e o);
    if (o == eelr_pkg::OvrL) return eelr_pkg::ClsL;
    if (o == eelr_pkg::OvrR) return eelr_pkg::ClsR;
    return cls;
  endfunction

  function automatic bit push_entry(int unsigned lvl, eelr_pkg::ovr_e o, logic iso);
    if (lvl <= eelr_pkg::MaxLevel && ovf_iso == 0 && ovf_emb == 0 &&
        stk_top + 1 < eelr_pkg::StackDepth) begin
      stk_top++;
      lvl_stack[stk_top].level = lvl[eelr_pkg::LevelW-1:0];
      lvl_stack[stk_top].ovr   = o;
      lvl_stack[stk_top].iso   = iso;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic char_res_t resolve_char(logic [eelr_pkg::ClassW-1:0] cls, logic ps,
                                             logic pl);
    eelr_pkg::entry_t top_e;
    int unsigned      next_lvl;
    eelr_pkg::ovr_e   new_ovr;
    char_res_t        r;
    if (ps) begin
      clear_levels();
      lvl_stack[0].level = {{(eelr_pkg::LevelW-1){1'b0}}, pl};
      lvl_stack[0].ovr   = eelr_pkg::OvrNone;
      lvl_stack[0].iso   = 1'b0;
    end
    top_e     = lvl_stack[stk_top];
    r.level   = top_e.level;
    r.cls     = cls;
    r.removed = 1'b0;
    case (cls) inside
      eelr_pkg::ClsLre, eelr_pkg::ClsLro, eelr_pkg::ClsRle, eelr_pkg::ClsRlo: begin
        if (cls == eelr_pkg::ClsRle || cls == eelr_pkg::ClsRlo)
          next_lvl = top_e.level + (top_e.level[0] ? 2 : 1);
        else
          next_lvl = top_e.level + (top_e.level[0] ? 1 : 2);
        new_ovr   = (cls == eelr_pkg::ClsRlo) ? eelr_pkg::OvrR :
                    (cls == eelr_pkg::ClsLro) ? eelr_pkg::OvrL : eelr_pkg::OvrNone;
        r.removed = 1'b1;
        if (!push_entry(next_lvl, new_ovr, 1'b0) && ovf_iso == 0 && ovf_emb < CounterMax)
          ovf_emb++;
      end
      eelr_pkg::ClsLri, eelr_pkg::ClsRli: begin
        if (cls == eelr_pkg::ClsRli)
          next_lvl = top_e.level + (top_e.level[0] ? 2 : 1);
        else
          next_lvl = top_e.level + (top_e.level[0] ? 1 : 2);
        r.cls = with_override(cls, top_e.ovr);
        if (push_entry(next_lvl, eelr_pkg::OvrNone, 1'b1)) begin
          if (iso_open < eelr_pkg::ValidIsoMax) iso_open++;
        end else if (ovf_iso < CounterMax) begin
          ovf_iso++;
        end
      end
      eelr_pkg::ClsPdi: begin
        if (ovf_iso > 0) begin
          ovf_iso--;
        end else if (iso_open != 0) begin
          ovf_emb = 0;
          while (stk_top > 0 && !lvl_stack[stk_top].iso) stk_top--;
          if (stk_top > 0) stk_top--;
          iso_open--;
        end
        r.level = lvl_stack[stk_top].level;
        r.cls   = with_override(cls, lvl_stack[stk_top].ovr);
      end
      eelr_pkg::ClsPdf: begin
        r.removed = 1'b1;
        if (ovf_iso > 0) begin
          // inside an overflowed isolate
        end else if (ovf_emb > 0) begin
          ovf_emb--;
        end else if (!top_e.iso && stk_top >= 1) begin
          stk_top--;
        end
      end
      eelr_pkg::ClsBn: r.removed = 1'b1;
      eelr_pkg::ClsB: begin
        clear_levels();
        r.level = lvl_stack[0].level;
      end
      default: r.cls = with_override(cls, top_e.ovr);
    endcase
    return r;
  endfunction

  // sender: valid stays high across back-to-back beats
  task automatic send_char(logic [eelr_pkg::ClassW-1:0] cls, logic ps = 1'b0,
                           logic pl = logic'($urandom_range(1)));
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.bidi_class      <= cls;
    in_if.paragraph_start <= ps;
    in_if.paragraph_level <= pl;
    do @(posedge clk_i); while (!in_if.ready);
    pending_res.push_back(resolve_char(cls, ps, pl));
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() > 0);
  endtask

  function automatic logic [eelr_pkg::ClassW-1:0] pick_text();
    int unsigned r;
    logic [eelr_pkg::ClassW-1:0] c;
    r = $urandom_range(99);
    if (r < 80) begin
      c = 5'($urandom_range(0, 13));
      if (c == eelr_pkg::ClsB) c = eelr_pkg::ClsWs;
    end else if (r < 90) begin
      c = eelr_pkg::ClsBn;
    end else if (r < 95) begin
      c = eelr_pkg::ClsFsi;
    end else begin
      c = 5'($urandom_range(23, 31));
    end
    return c;
  endfunction

  function automatic logic [eelr_pkg::ClassW-1:0] pick_embedding();
    case ($urandom_range(3))
      0:       return eelr_pkg::ClsLre;
      1:       return eelr_pkg::ClsRle;
      2:       return eelr_pkg::ClsLro;
      default: return eelr_pkg::ClsRlo;
    endcase
  endfunction

  function automatic logic [eelr_pkg::ClassW-1:0] pick_isolate();
    return $urandom_range(1) ? eelr_pkg::ClsRli : eelr_pkg::ClsLri;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    char_res_t got;
    char_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{level: out_if.embedding_level, cls: out_if.resolved_class,
              removed: out_if.removed_by_x9};
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result: level %0d class %0d removed %0b",
                 $time, got.level, got.cls, got.removed);
        mismatch_count++;
      end else begin
        want = pending_res.pop_front();
        if (got.level !== want.level) begin
          $display("%0t level mismatch: expected %0d actual %0d", $time, want.level, got.level);
          mismatch_count++;
        end
        if (got.cls !== want.cls) begin
          $display("%0t class mismatch: expected %0d actual %0d", $time, want.cls, got.cls);
          mismatch_count++;
        end
        if (got.removed !== want.removed) begin
          $display("%0t removed flag mismatch: expected %0b actual %0b",
                   $time, want.removed, got.removed);
          mismatch_count++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic test_directed();
    send_char(eelr_pkg::ClsL, 1'b1, 1'b0);
    send_char(eelr_pkg::ClsR, 1'b1, 1'b1);
    send_char(eelr_pkg::ClsAl);
    send_char(eelr_pkg::ClsEn);
    send_char(eelr_pkg::ClsRle);
    send_char(eelr_pkg::ClsEs);
    send_char(eelr_pkg::ClsLro);
    send_char(eelr_pkg::ClsAn);
    send_char(eelr_pkg::ClsPdf);
    send_char(eelr_pkg::ClsRlo);
    send_char(eelr_pkg::ClsEt);
    send_char(eelr_pkg::ClsLri);
    send_char(eelr_pkg::ClsCs);
    send_char(eelr_pkg::ClsPdf);
    send_char(eelr_pkg::ClsRli);
    send_char(eelr_pkg::ClsNsm);
    send_char(eelr_pkg::ClsPdi);
    send_char(eelr_pkg::ClsPdi);
    send_char(eelr_pkg::ClsPdi);
    send_char(eelr_pkg::ClsBn);
    send_char(eelr_pkg::ClsFsi);
    send_char(5'd23);
    send_char(5'd31);
    send_char(eelr_pkg::ClsS);
    send_char(eelr_pkg::ClsB);
    send_char(eelr_pkg::ClsWs);
    send_char(eelr_pkg::ClsOn, 1'b1, 1'b0);
  endtask

  task automatic test_deep_nesting();
    send_char(eelr_pkg::ClsL, 1'b1, logic'($urandom_range(1)));
    // embeddings past the top level, then unwind
    repeat (100) begin
      send_char(pick_embedding());
      if ($urandom_range(7) == 0) send_char(pick_text());
    end
    repeat (105) begin
      send_char(eelr_pkg::ClsPdf);
      if ($urandom_range(7) == 0) send_char(pick_text());
    end
    hold_until_drained();
    // isolates nested with embeddings until isolates overflow
    repeat (45) begin
      send_char(pick_isolate());
      send_char(pick_embedding());
    end
    send_char(pick_text());
    send_char(eelr_pkg::ClsPdf);
    repeat (50) begin
      send_char(eelr_pkg::ClsPdi);
      if ($urandom_range(7) == 0) send_char(pick_text());
    end
    // one isolate closing a long run of embeddings
    send_char(pick_isolate());
    repeat (60) send_char(pick_embedding());
    send_char(eelr_pkg::ClsPdi);
    send_char(pick_text());
    send_char(eelr_pkg::ClsB);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned open_pct;
    int unsigned r;
    open_pct = 30;
    send_char(pick_text(), 1'b1, logic'($urandom_range(1)));
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) open_pct = $urandom_range(15, 45);
      r = $urandom_range(99);
      if (r < open_pct)
        send_char(($urandom_range(9) < 7) ? pick_embedding() : pick_isolate());
      else if (r < open_pct + 20)
        send_char(($urandom_range(9) < 7) ? eelr_pkg::ClsPdf : eelr_pkg::ClsPdi);
      else if (r < 98)
        send_char(pick_text());
      else if (r == 98)
        send_char(eelr_pkg::ClsB);
      else
        send_char(5'($urandom_range(31)), 1'b1, logic'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.bidi_class       <= eelr_pkg::ClsL;
    in_if.paragraph_start  <= 1'b0;
    in_if.paragraph_level  <= 1'b0;
    mismatch_count = 0;
    src_idle_pct   = 17;
    snk_idle_pct   = 70;
    for (int i = 0; i < eelr_pkg::StackDepth; i++) lvl_stack[i] = '0;
    clear_levels();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_deep_nesting();
    test_random(45);
    src_idle_pct = 70;
    snk_idle_pct = 17;
    test_random(45);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(45);

    in_if.valid <= 1'b0;
    while (pending_res.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("PASS explicit_embedding_level_resolver_unit");
    else
      $display("FAIL explicit_embedding_level_resolver_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL explicit_embedding_level_resolver_unit");
    $finish;
  end

endmodule
